/* src/kcd_pkg.sv */
`timescale 1ns / 1ps

package kcd_pkg;

    localparam int SLOT_COUNT  = 10;
    localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);
    localparam int CODE_W      = 10;
    localparam int TYPE_W      = 5;
    localparam int VALUE_W     = 2;
    localparam int CHORD_COUNT = 3;
    localparam int POS_COUNT   = 3;
    localparam int CHORD_W     = CODE_W * POS_COUNT;
    localparam int CFG_IDX_W   = 2;

    localparam logic [TYPE_W-1:0]  EV_KEY      = 5'd1;
    localparam logic [VALUE_W-1:0] KEY_RELEASE = 2'd0;
    localparam logic [VALUE_W-1:0] KEY_PRESS   = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_CHORD_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHORD_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHORD_C = 2'd2;

    localparam logic [CHORD_W-1:0] CHORD_A_RESET = 30'd18457;
    localparam logic [CHORD_W-1:0] CHORD_B_RESET = 30'd26245166;
    localparam logic [CHORD_W-1:0] CHORD_C_RESET = 30'd35702808;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                  start;
        logic                  step;
        logic [SLOT_IDX_W-1:0] idx;
    } t_scan_ctrl;

    typedef logic [CHORD_W-1:0] t_chord_regs [CHORD_COUNT];

endpackage

/* src/kcd_if.sv */
`timescale 1ns / 1ps

interface kcd_in_if;
    import kcd_pkg::*;

    logic                valid;
    logic                ready;
    logic [TYPE_W-1:0]   event_type;
    logic [CODE_W-1:0]   key_code;
    logic [VALUE_W-1:0]  key_value;

    modport source (output valid, output event_type, output key_code, output key_value,
                    input ready);
    modport sink   (input valid, input event_type, input key_code, input key_value,
                    output ready);
endinterface

interface kcd_out_if;
    logic valid;
    logic ready;
    logic chord_a_held;
    logic chord_b_held;
    logic chord_c_held;

    modport source (output valid, output chord_a_held, output chord_b_held,
                    output chord_c_held, input ready);
    modport sink   (input valid, input chord_a_held, input chord_b_held,
                    input chord_c_held, output ready);
endinterface

/* src/kcd_scan_unit.sv */
`timescale 1ns / 1ps

module kcd_scan_unit
    import kcd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_scan_ctrl             i_ctrl,
    input  logic [TYPE_W-1:0]      i_event_type,
    input  logic [CODE_W-1:0]      i_key_code,
    input  logic [VALUE_W-1:0]     i_key_value,
    input  t_chord_regs            i_chord,
    output logic [CHORD_COUNT-1:0] o_held
);

    logic                                   r_slot_valid [SLOT_COUNT];
    logic [CODE_W-1:0]                      r_slot_code  [SLOT_COUNT];
    logic                                   r_pending;
    logic                                   r_is_press;
    logic [CODE_W-1:0]                      r_key;
    logic [CHORD_COUNT-1:0][POS_COUNT-1:0]  r_found;
    logic [CHORD_COUNT-1:0][POS_COUNT-1:0]  n_found;

    logic              sel_valid;
    logic [CODE_W-1:0] sel_code;
    logic              hit_press;
    logic              hit_release;
    logic              eff_valid;
    logic [CODE_W-1:0] eff_code;

    // The slot under the scan pointer is updated and checked in the same cycle, so a
    // single pass both applies the event and gathers the chord matches.
    always_comb begin
        sel_valid   = r_slot_valid[i_ctrl.idx];
        sel_code    = r_slot_code[i_ctrl.idx];
        hit_press   = r_pending && r_is_press && !sel_valid;
        hit_release = r_pending && !r_is_press && sel_valid && (sel_code == r_key);
        eff_valid   = hit_press || (sel_valid && !hit_release);
        eff_code    = hit_press ? r_key : sel_code;
        for (int c = 0; c < CHORD_COUNT; c++) begin
            for (int p = 0; p < POS_COUNT; p++) begin
                n_found[c][p] = r_found[c][p] ||
                    (eff_valid && (eff_code == i_chord[c][p*CODE_W +: CODE_W]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_valid[i] <= 1'b0;
            end
        end else if (i_ctrl.start) begin
            r_pending  <= (i_event_type == EV_KEY) &&
                          ((i_key_value == KEY_PRESS) || (i_key_value == KEY_RELEASE));
            r_is_press <= (i_key_value == KEY_PRESS);
            r_key      <= i_key_code;
            r_found    <= '0;
        end else if (i_ctrl.step) begin
            r_found <= n_found;
            if (hit_press || hit_release) begin
                r_pending                   <= 1'b0;
                r_slot_valid[i_ctrl.idx]    <= eff_valid;
                r_slot_code[i_ctrl.idx]     <= eff_code;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < CHORD_COUNT; c++) begin
            logic       used;
            logic       all_found;
            used      = 1'b0;
            all_found = 1'b1;
            for (int p = 0; p < POS_COUNT; p++) begin
                if (i_chord[c][p*CODE_W +: CODE_W] != '0) begin
                    used      = 1'b1;
                    all_found = all_found && r_found[c][p];
                end
            end
            o_held[c] = used && all_found;
        end
    end

endmodule

/* src/key_chord_detector_unit.sv */
`timescale 1ns / 1ps
// The slot scan visits one of the ten held-key slots per cycle through a single update and
// compare datapath. A new transaction is taken only in the idle state, after the scan of
// the previous one ends and its result has been loaded into the output register.
// A finished result waits in an output register while the next transaction is taken.
// Synchronous active-low reset empties every slot and restores the chord registers.

module key_chord_detector_unit
    import kcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CHORD_W-1:0]   i_cfg_data,
    kcd_in_if.sink               i_ev,
    kcd_out_if.source            o_res
);

    t_state                 r_state;
    t_state                 n_state;
    logic [SLOT_IDX_W-1:0]  r_idx;
    logic [SLOT_IDX_W-1:0]  n_idx;
    t_chord_regs            r_chord;
    logic                   r_out_valid;
    logic [CHORD_COUNT-1:0] r_flags;
    logic [CHORD_COUNT-1:0] scan_held;
    t_scan_ctrl             ctrl;
    logic                   in_accept;
    logic                   load_out;
    logic                   last_slot;

    assign in_accept = i_ev.valid && i_ev.ready;
    assign last_slot = (r_idx == SLOT_IDX_W'(SLOT_COUNT - 1));
    assign load_out  = (r_state == ST_FINISH) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (in_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (last_slot) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_ev.ready = (r_state == ST_IDLE);
        ctrl.start = in_accept;
        ctrl.step  = (r_state == ST_SCAN);
        ctrl.idx   = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_flags <= scan_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chord[0] <= CHORD_A_RESET;
            r_chord[1] <= CHORD_B_RESET;
            r_chord[2] <= CHORD_C_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHORD_A: r_chord[0] <= i_cfg_data;
                CFG_CHORD_B: r_chord[1] <= i_cfg_data;
                CFG_CHORD_C: r_chord[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    kcd_scan_unit u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_event_type (i_ev.event_type),
        .i_key_code   (i_ev.key_code),
        .i_key_value  (i_ev.key_value),
        .i_chord      (r_chord),
        .o_held       (scan_held)
    );

    assign o_res.valid        = r_out_valid;
    assign o_res.chord_a_held = r_flags[0];
    assign o_res.chord_b_held = r_flags[1];
    assign o_res.chord_c_held = r_flags[2];

endmodule

/* src/kcd_checker.sv */
`timescale 1ns / 1ps

module kcd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_a_held,
    input logic i_b_held,
    input logic i_c_held
);

    logic in_accept;
    assign in_accept = i_in_valid && i_in_ready;

    // A result that is not taken must stay on offer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before its transaction");

    // A stalled result keeps its flags.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_a_held, i_b_held, i_c_held}))
        else $error("result flags changed while stalled");

    // The block is busy with the slot scan straight after taking a transaction.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !i_in_ready)
        else $error("input ready while the scan is running");

    // The scan visits every slot before the next transaction can be taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> ##11 !i_in_ready || $past(i_in_ready))
        else $error("transaction taken before the scan finished");

    // A new result appears only at the end of a scan, loaded while the block is not ready for input.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without a finished scan");

endmodule

bind key_chord_detector_unit kcd_checker u_kcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_ev.valid),
    .i_in_ready  (i_ev.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_a_held    (o_res.chord_a_held),
    .i_b_held    (o_res.chord_b_held),
    .i_c_held    (o_res.chord_c_held)
);

/* verif/key_chord_detector_unit_tb.sv */
`timescale 1ns / 1ps

module key_chord_detector_unit_tb;
    import kcd_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 250000;
    localparam int REPORT_MAX  = 10;
    localparam int POOL_SIZE   = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 145;
    localparam int SETTLE      = 16;

    localparam logic [VALUE_W-1:0]   KEY_REPEAT   = 2'd2;
    localparam logic [VALUE_W-1:0]   KEY_RSVD     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam logic [CODE_W-1:0] KEY_E = 10'd18;
    localparam logic [CODE_W-1:0] KEY_O = 10'd24;
    localparam logic [CODE_W-1:0] KEY_P = 10'd25;
    localparam logic [CODE_W-1:0] KEY_A = 10'd30;
    localparam logic [CODE_W-1:0] KEY_G = 10'd34;
    localparam logic [CODE_W-1:0] KEY_C = 10'd46;
    localparam logic [CODE_W-1:0] KEY_M = 10'd50;
    localparam logic [CODE_W-1:0] CODE_MAX = 10'd1023;

    typedef struct packed {
        logic [TYPE_W-1:0]  ev_type;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
    } t_key_event;

    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } t_chord_flags;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CHORD_W-1:0]   cfg_data;

    kcd_in_if  ev_if ();
    kcd_out_if res_if ();

    key_chord_detector_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_ev       (ev_if),
        .o_res      (res_if)
    );

    t_key_event         pending_events [$];
    t_chord_flags       expected_flags [$];
    logic [CODE_W-1:0]  stim_held [$];
    logic [CODE_W-1:0]  code_pool [POOL_SIZE];

    logic               slot_used [SLOT_COUNT];
    logic [CODE_W-1:0]  slot_key  [SLOT_COUNT];
    logic [CHORD_W-1:0] chord_cfg [CHORD_COUNT];

    logic ev_taken;
    logic res_taken;
    int   feed_gap;
    int   feed_gap_max;
    int   stall_left;
    int   stall_max;
    int   mismatches;
    int   cycles;

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic key_held(logic [CODE_W-1:0] code);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_used[i] && slot_key[i] == code) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic chord_complete(logic [CHORD_W-1:0] chord);
        logic [CODE_W-1:0] code;
        int                used;
        logic              all_held;
        used     = 0;
        all_held = 1'b1;
        for (int p = 0; p < POS_COUNT; p++) begin
            code = chord[p*CODE_W +: CODE_W];
            if (code != '0) begin
                used++;
                if (!key_held(code)) begin
                    all_held = 1'b0;
                end
            end
        end
        return (used > 0) && all_held;
    endfunction

    function automatic t_chord_flags track_key_event(t_key_event ev);
        t_chord_flags flags;
        if (ev.ev_type == EV_KEY) begin
            if (ev.value == KEY_RELEASE) begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (slot_used[i] && slot_key[i] == ev.code) begin
                        slot_used[i] = 1'b0;
                        slot_key[i]  = '0;
                        break;
                    end
                end
            end else if (ev.value == KEY_PRESS) begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!slot_used[i]) begin
                        slot_used[i] = 1'b1;
                        slot_key[i]  = ev.code;
                        break;
                    end
                end
            end
        end
        flags.a = chord_complete(chord_cfg[0]);
        flags.b = chord_complete(chord_cfg[1]);
        flags.c = chord_complete(chord_cfg[2]);
        return flags;
    endfunction

    function automatic logic [CHORD_W-1:0] chord_of(logic [CODE_W-1:0] c0,
                                                    logic [CODE_W-1:0] c1,
                                                    logic [CODE_W-1:0] c2);
        return {c2, c1, c0};
    endfunction

    // The stimulus side keeps its own list of held codes so that releases mostly hit.
    task automatic queue_event(logic [TYPE_W-1:0] ev_type, logic [CODE_W-1:0] code,
                               logic [VALUE_W-1:0] value);
        t_key_event ev;
        ev.ev_type = ev_type;
        ev.code    = code;
        ev.value   = value;
        pending_events.push_back(ev);
        if (ev_type == EV_KEY && value == KEY_PRESS && stim_held.size() < SLOT_COUNT) begin
            stim_held.push_back(code);
        end else if (ev_type == EV_KEY && value == KEY_RELEASE) begin
            for (int i = 0; i < stim_held.size(); i++) begin
                if (stim_held[i] == code) begin
                    stim_held.delete(i);
                    break;
                end
            end
        end
    endtask

    task automatic queue_random_events(int count);
        logic [TYPE_W-1:0]  ev_type;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
        int                 r;
        for (int n = 0; n < count; n++) begin
            ev_type = ($urandom_range(0, 99) < 8) ? TYPE_W'($urandom_range(0, 31)) : EV_KEY;
            code = ($urandom_range(0, 9) == 0) ? CODE_W'($urandom)
                                                : code_pool[$urandom_range(0, POOL_SIZE - 1)];
            r = $urandom_range(0, 99);
            if (r < 8) begin
                value = VALUE_W'($urandom_range(2, 3));
            end else if (stim_held.size() == 0) begin
                value = KEY_PRESS;
            end else if (stim_held.size() >= SLOT_COUNT) begin
                value = (r < 80) ? KEY_RELEASE : KEY_PRESS;
            end else begin
                value = (r < 56) ? KEY_PRESS : KEY_RELEASE;
            end
            if (value == KEY_RELEASE && stim_held.size() > 0 && $urandom_range(0, 4) != 0) begin
                code = stim_held[$urandom_range(0, stim_held.size() - 1)];
            end
            queue_event(ev_type, code, value);
        end
    endtask

    task automatic write_chord(logic [CFG_IDX_W-1:0] idx, logic [CHORD_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx < CHORD_COUNT) begin
            chord_cfg[idx] = data;
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (pending_events.size() != 0 || ev_if.valid || expected_flags.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Input side: predict at acceptance, present the next event at the falling edge.
    always @(posedge i_clk) begin
        t_key_event ev;
        ev_taken <= i_rst_n && ev_if.valid && ev_if.ready;
        if (i_rst_n && ev_if.valid && ev_if.ready) begin
            ev.ev_type = ev_if.event_type;
            ev.code    = ev_if.key_code;
            ev.value   = ev_if.key_value;
            expected_flags.push_back(track_key_event(ev));
        end
    end

    always @(negedge i_clk) begin
        t_key_event nxt;
        if (!i_rst_n) begin
            ev_if.valid <= 1'b0;
        end else begin
            if (ev_taken) begin
                feed_gap = $urandom_range(0, feed_gap_max);
            end
            if (!ev_if.valid || ev_taken) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                    ev_if.valid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    nxt = pending_events.pop_front();
                    ev_if.valid      <= 1'b1;
                    ev_if.event_type <= nxt.ev_type;
                    ev_if.key_code   <= nxt.code;
                    ev_if.key_value  <= nxt.value;
                end else begin
                    ev_if.valid <= 1'b0;
                end
            end
        end
    end

    // Output side: compare every result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_chord_flags want;
        res_taken <= i_rst_n && res_if.valid && res_if.ready;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_flags.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result: a=%0b b=%0b c=%0b", res_if.chord_a_held,
                             res_if.chord_b_held, res_if.chord_c_held);
                end
            end else begin
                want = expected_flags.pop_front();
                if (res_if.chord_a_held !== want.a || res_if.chord_b_held !== want.b ||
                    res_if.chord_c_held !== want.c) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("chord flag mismatch: expected a=%0b b=%0b c=%0b, got a=%0b b=%0b c=%0b",
                                 want.a, want.b, want.c, res_if.chord_a_held,
                                 res_if.chord_b_held, res_if.chord_c_held);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_taken) begin
                stall_left = $urandom_range(0, stall_max);
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [CHORD_W-1:0] chords [CHORD_COUNT];
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        ev_if.valid      = 1'b0;
        ev_if.event_type = '0;
        ev_if.key_code   = '0;
        ev_if.key_value  = '0;
        res_if.ready     = 1'b0;
        ev_taken         = 1'b0;
        res_taken        = 1'b0;
        feed_gap         = 0;
        stall_left       = 0;
        feed_gap_max     = 5;
        stall_max        = 5;
        mismatches       = 0;
        cycles           = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
        end
        chord_cfg[0] = CHORD_A_RESET;
        chord_cfg[1] = CHORD_B_RESET;
        chord_cfg[2] = CHORD_C_RESET;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        queue_event(EV_KEY, KEY_P, KEY_PRESS);
        queue_event(EV_KEY, KEY_E, KEY_PRESS);
        queue_event(TYPE_W'(0), KEY_P, KEY_PRESS);
        queue_event(EV_KEY, KEY_C, KEY_PRESS);
        queue_event(EV_KEY, KEY_A, KEY_PRESS);
        queue_event(EV_KEY, KEY_O, KEY_REPEAT);
        queue_event(EV_KEY, KEY_M, KEY_RSVD);
        queue_event(TYPE_W'(31), CODE_MAX, KEY_RSVD);
        queue_event(EV_KEY, KEY_E, KEY_RELEASE);
        queue_event(EV_KEY, KEY_G, KEY_RELEASE);
        queue_event(EV_KEY, KEY_P, KEY_PRESS);
        queue_event(EV_KEY, KEY_P, KEY_RELEASE);
        queue_event(EV_KEY, KEY_E, KEY_PRESS);
        queue_event(EV_KEY, CODE_W'(0), KEY_PRESS);
        queue_event(EV_KEY, CODE_MAX, KEY_PRESS);
        queue_event(EV_KEY, KEY_O, KEY_PRESS);
        queue_event(EV_KEY, KEY_M, KEY_PRESS);
        queue_event(EV_KEY, CODE_MAX, KEY_PRESS);
        queue_event(EV_KEY, CODE_W'(0), KEY_PRESS);
        queue_event(EV_KEY, KEY_G, KEY_PRESS);
        queue_event(EV_KEY, CODE_W'(0), KEY_RELEASE);
        queue_event(EV_KEY, KEY_G, KEY_PRESS);
        queue_event(EV_KEY, KEY_M, KEY_RELEASE);
        queue_event(TYPE_W'(30), CODE_W'(10'h2AA), KEY_RELEASE);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            code_pool[0] = '0;
            code_pool[1] = CODE_MAX;
            code_pool[2] = CODE_W'(1);
            for (int i = 3; i < POOL_SIZE; i++) begin
                code_pool[i] = CODE_W'($urandom_range(1, 1023));
            end
            for (int c = 0; c < CHORD_COUNT; c++) begin
                for (int p = 0; p < POS_COUNT; p++) begin
                    chords[c][p*CODE_W +: CODE_W] = ($urandom_range(0, 3) == 0) ? '0
                        : code_pool[$urandom_range(1, POOL_SIZE - 1)];
                end
            end
            if (phase == 0) begin
                chords[0] = '0;
                chords[1] = '1;
                chords[2] = chord_of('0, '0, code_pool[3]);
            end else if (phase == 2) begin
                chords[0] = chord_of(code_pool[4], code_pool[4], '0);
                chords[1] = chord_of('0, code_pool[5], '0);
            end
            write_chord(CFG_CHORD_A, chords[0]);
            write_chord(CFG_CHORD_B, chords[1]);
            write_chord(CFG_CHORD_C, chords[2]);
            if (phase % 2 == 1) begin
                write_chord(CFG_UNMAPPED, CHORD_W'($urandom));
            end
            feed_gap_max = (phase % 3 == 0) ? 0 : 5;
            stall_max    = (phase % 3 == 1) ? 0 : 5;
            queue_random_events(PHASE_ITEMS);
            wait_drained();
        end

        if (mismatches == 0 && expected_flags.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
